[design/huf_pkg.sv]
// shared types and constants for the huffman tree bit decoder
`default_nettype none
package huf_pkg;

  // node index and stored link widths
  localparam int IDX_W  = 9;
  localparam int LINK_W = 2 * IDX_W;
  localparam int CUR_W  = IDX_W + 1;

  // input item modes
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_DECODE  = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // walk sequencer states
  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_CHILD  = 1'b1
  } state_t;

endpackage
`default_nettype wire

[design/huf_node_mem.sv]
// node link table, one write port and one registered read port
`default_nettype none
module huf_node_mem
  import huf_pkg::*;
#(
  parameter int DEPTH = 511,
  parameter int AW    = 9
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [LINK_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/huffman_tree_bit_decoder_unit.sv]
// Decode: a transaction reads the node memory twice, current node then chosen child,
//   and its symbol is registered into the output when that child is a leaf.
//   ST_CHILD, which issues the dependent second read, and a stalled symbol hold off
//   new transactions; load, restart and ignored transactions never leave ST_ACCEPT.
// Reset (rst_n low, synchronous): walk returns to the root, symbol count is zero,
//   output is empty; the node table keeps its contents and is undefined until loaded.
`default_nettype none
module huffman_tree_bit_decoder_unit
  import huf_pkg::*;
#(
  parameter int MAX_SYMBOLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // mode[1:0], node_index[10:2], left_index[19:11],
                                       // right_index[28:20], code_bit[29], zero[31:30]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // symbol_rank[7:0]
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data    // symbol_count[8:0]
);

  localparam int DEPTH    = 2 * MAX_SYMBOLS - 1;
  localparam int MemDepth = (DEPTH > (1 << IDX_W)) ? (1 << IDX_W) : DEPTH;
  localparam int AW       = $clog2(MemDepth);
  localparam int CntCap   = (MAX_SYMBOLS > (1 << IDX_W) - 1) ? (1 << IDX_W) - 1 : MAX_SYMBOLS;
  localparam logic [IDX_W-1:0] CNT_CAP   = IDX_W'(CntCap);
  localparam logic [CUR_W:0]   MEM_LIMIT = (CUR_W + 1)'(MemDepth);

  // input field unpacking
  mode_t            in_mode;
  logic [IDX_W-1:0] in_node;
  logic [IDX_W-1:0] in_left;
  logic [IDX_W-1:0] in_right;
  logic             in_bit;

  assign in_mode  = mode_t'(in_tdata[1:0]);
  assign in_node  = in_tdata[10:2];
  assign in_left  = in_tdata[19:11];
  assign in_right = in_tdata[28:20];
  assign in_bit   = in_tdata[29];

  // registers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  count_r;
  logic              fin_r, fin_nxt;
  logic              bit_r;
  logic [IDX_W-1:0]  next_r;
  logic              oob_r, oob_nxt;
  logic [IDX_W-1:0]  walk_node_r, walk_node_nxt;
  logic              walk_at_root_r, walk_at_root_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_rank_r;

  // combinational signals
  logic              acc;
  logic              dec_go;
  logic [IDX_W-1:0]  cnt_eff;
  logic [CUR_W-1:0]  root;
  logic [LINK_W-1:0] rd_data;
  logic [LINK_W-1:0] links;
  logic [IDX_W-1:0]  l_idx;
  logic [IDX_W-1:0]  r_idx;
  logic              leaf;
  logic              stall;
  logic              fin_go;
  logic              at_root_eff;
  logic [IDX_W-1:0]  node_eff;
  logic [CUR_W-1:0]  cur;
  logic [IDX_W-1:0]  child;
  logic              rd_en;
  logic [CUR_W-1:0]  rd_idx;
  logic              wr_en;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // saturated count and root index
  assign cnt_eff = (count_r > CNT_CAP) ? CNT_CAP : count_r;
  assign root    = {cnt_eff, 1'b0} - CUR_W'(2);

  // links of the node read last, out-of-table nodes read as zero links
  assign links = oob_r ? '0 : rd_data;
  assign l_idx = links[IDX_W-1:0];
  assign r_idx = links[LINK_W-1:IDX_W];
  assign leaf  = (l_idx == r_idx);
  assign child = bit_r ? r_idx : l_idx;

  // finishing decode holds when its symbol finds the output full
  assign stall  = fin_r && leaf && out_valid_r && !out_tready;
  assign fin_go = fin_r && !stall;

  // walk position as seen by the next transaction, forwarded from a finishing decode
  assign at_root_eff = fin_r ? leaf : walk_at_root_r;
  assign node_eff    = (fin_r && !leaf) ? next_r : walk_node_r;
  assign cur         = at_root_eff ? root : {1'b0, node_eff};

  assign acc    = in_tvalid && in_tready;
  assign dec_go = acc && (in_mode == MODE_DECODE) && (cnt_eff != '0);
  assign wr_en  = acc && (in_mode == MODE_LOAD) && ({2'b0, in_node} < MEM_LIMIT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACCEPT: begin
        if (dec_go) begin
          state_nxt = ST_CHILD;
        end
      end
      ST_CHILD: begin
        state_nxt = ST_ACCEPT;
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  // sequencer outputs: ready and memory read issue
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = cur;
    case (state_r)
      ST_ACCEPT: begin
        in_tready = !stall;
        rd_en     = dec_go;
        rd_idx    = cur;
      end
      ST_CHILD: begin
        rd_en  = 1'b1;
        rd_idx = {1'b0, child};
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign oob_nxt = rd_en ? !({1'b0, rd_idx} < MEM_LIMIT) : oob_r;
  assign fin_nxt = (state_r == ST_CHILD) || stall;

  // walk state update
  always_comb begin
    walk_at_root_nxt = fin_go ? leaf : walk_at_root_r;
    walk_node_nxt    = (fin_go && !leaf) ? next_r : walk_node_r;
    if (acc && (in_mode == MODE_RESTART)) begin
      walk_at_root_nxt = 1'b1;
    end
  end

  // output register
  assign out_valid_nxt = (fin_go && leaf) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_ACCEPT;
      fin_r          <= 1'b0;
      oob_r          <= 1'b0;
      walk_node_r    <= '0;
      walk_at_root_r <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fin_r          <= fin_nxt;
      oob_r          <= oob_nxt;
      walk_node_r    <= walk_node_nxt;
      walk_at_root_r <= walk_at_root_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dec_go) begin
      bit_r <= in_bit;
    end
    if (state_r == ST_CHILD) begin
      next_r <= child;
    end
    if (fin_go && leaf) begin
      out_rank_r <= next_r[7:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rank_r;

  // node link memory
  huf_node_mem #(
    .DEPTH (MemDepth),
    .AW    (AW)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_node[AW-1:0]),
    .wr_data ({in_right, in_left}),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

[design/huf_checker.sv]
// port-level checks for the huffman tree bit decoder, bound to the top level
`default_nettype none
module huf_checker
  import huf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata
);

  // a stalled result transaction keeps its symbol
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result directly after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result present after reset");

  // a non-decode transaction leaves the block ready in the next cycle
  a_ready_after_nondecode: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != MODE_DECODE) |=> in_tready)
    else $error("not ready after a load or restart transaction");

  // a fresh result comes from a decode transaction, its child read in ST_CHILD and its leaf symbol registered
  a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(in_tvalid && in_tready && (in_tdata[1:0] == MODE_DECODE), 3))
    else $error("result without a decode transaction");

endmodule

bind huffman_tree_bit_decoder_unit huf_checker u_huf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
